FILE: rtl/vcsg_pkg.sv
package vcsg_pkg;

    localparam int OPCODE_W = 4;
    localparam int TS_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LIMIT_W = 15;
    localparam int ACCEL_W = 16;
    localparam int DB_W = 16;
    localparam int DT_W = 32;
    localparam int CODE_W = 3;

    localparam logic [OPCODE_W-1:0] OP_CONNECT     = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_DISCONNECT  = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_ENABLE      = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_DISABLE     = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_READY       = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_COMMAND     = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_TICK        = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_ESTOP       = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_ESTOP = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_TF_STALE    = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_SENSOR_STALE = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_BRIDGE_ERROR = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_COLLISION   = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_FAULT = 4'd13;

    localparam logic [CODE_W-1:0] FAULT_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] FAULT_TIMEOUT  = 3'd1;
    localparam logic [CODE_W-1:0] FAULT_TF       = 3'd2;
    localparam logic [CODE_W-1:0] FAULT_SENSOR   = 3'd3;
    localparam logic [CODE_W-1:0] FAULT_BRIDGE   = 3'd4;

    localparam logic [CODE_W-1:0] MODE_CODE_DISC    = 3'd0;
    localparam logic [CODE_W-1:0] MODE_CODE_STANDBY = 3'd1;
    localparam logic [CODE_W-1:0] MODE_CODE_READY   = 3'd2;
    localparam logic [CODE_W-1:0] MODE_CODE_NAV     = 3'd3;
    localparam logic [CODE_W-1:0] MODE_CODE_FAULT   = 3'd4;
    localparam logic [CODE_W-1:0] MODE_CODE_ESTOP   = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_W  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_X  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_Y  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_W  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT  = 3'd7;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    typedef enum logic [5:0] {
        MODE_DISC    = 6'b000001,
        MODE_STANDBY = 6'b000010,
        MODE_READY   = 6'b000100,
        MODE_NAV     = 6'b001000,
        MODE_FAULT   = 6'b010000,
        MODE_ESTOP   = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] speed_limit_x;
        logic [LIMIT_W-1:0] speed_limit_y;
        logic [LIMIT_W-1:0] speed_limit_turn;
        logic [31:0]        deadband_pair;
        logic [ACCEL_W-1:0] accel_limit_x;
        logic [ACCEL_W-1:0] accel_limit_y;
        logic [ACCEL_W-1:0] accel_limit_turn;
        logic [15:0]        command_timeout;
    } cfg_t;

    typedef struct packed {
        logic              sent;
        logic              accepted;
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] fault_code;
    } status_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_DISC:    c = MODE_CODE_DISC;
            MODE_STANDBY: c = MODE_CODE_STANDBY;
            MODE_READY:   c = MODE_CODE_READY;
            MODE_NAV:     c = MODE_CODE_NAV;
            MODE_FAULT:   c = MODE_CODE_FAULT;
            MODE_ESTOP:   c = MODE_CODE_ESTOP;
            default:      c = MODE_CODE_DISC;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/vcsg_cfg_regs.sv
module vcsg_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vcsg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [vcsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output vcsg_pkg::cfg_t                     cfg
);
    import vcsg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_limit_x    <= '0;
            cfg_reg.speed_limit_y    <= '0;
            cfg_reg.speed_limit_turn <= '0;
            cfg_reg.deadband_pair    <= '0;
            cfg_reg.accel_limit_x    <= '0;
            cfg_reg.accel_limit_y    <= '0;
            cfg_reg.accel_limit_turn <= '0;
            cfg_reg.command_timeout  <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SPEED_X:  cfg_reg.speed_limit_x    <= cfg_wdata[LIMIT_W-1:0];
                REG_SPEED_Y:  cfg_reg.speed_limit_y    <= cfg_wdata[LIMIT_W-1:0];
                REG_SPEED_W:  cfg_reg.speed_limit_turn <= cfg_wdata[LIMIT_W-1:0];
                REG_DEADBAND: cfg_reg.deadband_pair    <= cfg_wdata[31:0];
                REG_ACCEL_X:  cfg_reg.accel_limit_x    <= cfg_wdata[ACCEL_W-1:0];
                REG_ACCEL_Y:  cfg_reg.accel_limit_y    <= cfg_wdata[ACCEL_W-1:0];
                REG_ACCEL_W:  cfg_reg.accel_limit_turn <= cfg_wdata[ACCEL_W-1:0];
                REG_TIMEOUT:  cfg_reg.command_timeout  <= cfg_wdata[15:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/vcsg_axis.sv
module vcsg_axis
#(
    parameter int VEL_WIDTH = 16
)
(
    input  logic signed [VEL_WIDTH-1:0]          target_in,
    input  logic signed [VEL_WIDTH-1:0]          prev,
    input  logic [vcsg_pkg::LIMIT_W-1:0]         limit,
    input  logic [vcsg_pkg::DB_W-1:0]            deadband,
    input  logic [vcsg_pkg::ACCEL_W-1:0]         accel,
    input  logic [vcsg_pkg::DT_W-1:0]            dt,
    output logic signed [VEL_WIDTH-1:0]          slewed
);
    import vcsg_pkg::*;

    localparam int W = ((VEL_WIDTH > 16) ? VEL_WIDTH : 16) + 2;
    localparam int PROD_W = ACCEL_W + DT_W;

    logic signed [W-1:0]  vin_w;
    logic signed [W-1:0]  prev_w;
    logic signed [W-1:0]  lim_w;
    logic signed [W-1:0]  db_w;
    logic signed [W-1:0]  clamped;
    logic signed [W-1:0]  mag;
    logic signed [W-1:0]  target;
    logic signed [W-1:0]  delta;
    logic signed [W-1:0]  maxd;
    logic signed [W-1:0]  step;
    logic signed [W-1:0]  sum;
    logic [PROD_W-1:0]    prod;

    assign vin_w  = W'(target_in);
    assign prev_w = W'(prev);
    assign lim_w  = W'(limit);
    assign db_w   = W'(deadband);

    // clamp to +-limit
    always_comb
    begin
        if (vin_w > lim_w)
            clamped = lim_w;
        else if (vin_w < -lim_w)
            clamped = -lim_w;
        else
            clamped = vin_w;
    end

    // deadband
    assign mag    = (clamped < 0) ? -clamped : clamped;
    assign target = (mag < db_w) ? '0 : clamped;

    // slew step (accel * dt) >> 8, saturated to the delta range
    assign prod = PROD_W'(accel) * PROD_W'(dt);

    always_comb
    begin
        if (|prod[PROD_W-1:W+7])
            maxd = {1'b0, {(W-1){1'b1}}};
        else
            maxd = {1'b0, prod[W+6:8]};
    end

    assign delta = target - prev_w;

    always_comb
    begin
        if (delta > maxd)
            step = maxd;
        else if (delta < -maxd)
            step = -maxd;
        else
            step = delta;
    end

    assign sum    = prev_w + step;
    assign slewed = sum[VEL_WIDTH-1:0];

endmodule

FILE: rtl/vcsg_core.sv
module vcsg_core
#(
    parameter int VEL_WIDTH  = 16,
    parameter int TIME_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  logic [vcsg_pkg::OPCODE_W-1:0]      opcode,
    input  logic [TIME_WIDTH-1:0]              now,
    input  logic signed [VEL_WIDTH-1:0]        vx_in,
    input  logic signed [VEL_WIDTH-1:0]        vy_in,
    input  logic signed [VEL_WIDTH-1:0]        wz_in,
    input  vcsg_pkg::cfg_t                     cfg,
    output logic signed [VEL_WIDTH-1:0]        vx_next,
    output logic signed [VEL_WIDTH-1:0]        vy_next,
    output logic signed [VEL_WIDTH-1:0]        wz_next,
    output vcsg_pkg::status_t                  status
);
    import vcsg_pkg::*;

    localparam logic [63:0] DT_SAT = 64'hFFFF_FFFF;

    mode_t                      mode_reg;
    mode_t                      mode_next;
    logic signed [VEL_WIDTH-1:0] vx_reg;
    logic signed [VEL_WIDTH-1:0] vy_reg;
    logic signed [VEL_WIDTH-1:0] wz_reg;
    logic [TIME_WIDTH-1:0]      step_time_reg;
    logic [TIME_WIDTH-1:0]      step_time_next;
    logic [TIME_WIDTH-1:0]      cmd_time_reg;
    logic [TIME_WIDTH-1:0]      cmd_time_next;
    logic                       seen_reg;
    logic                       seen_next;
    logic [CODE_W-1:0]          fault_reg;
    logic [CODE_W-1:0]          fault_next;

    logic [TIME_WIDTH-1:0]      step_diff;
    logic [TIME_WIDTH-1:0]      step_dt;
    logic [DT_W-1:0]            dt_sat;
    logic [TIME_WIDTH-1:0]      cmd_diff;
    logic                       timed_out;
    logic signed [VEL_WIDTH-1:0] vx_slew;
    logic signed [VEL_WIDTH-1:0] vy_slew;
    logic signed [VEL_WIDTH-1:0] wz_slew;

    logic                       sent;
    logic                       accepted;
    logic                       zero_vel;
    logic                       load_vel;
    logic                       fault_req;
    logic [CODE_W-1:0]          fault_val;

    // time since last step, negative counts as zero
    assign step_diff = now - step_time_reg;
    assign step_dt   = step_diff[TIME_WIDTH-1] ? '0 : step_diff;
    assign dt_sat    = (64'(step_dt) > DT_SAT) ? '1 : DT_W'(step_dt);

    // watchdog
    assign cmd_diff  = now - cmd_time_reg;
    assign timed_out = !cmd_diff[TIME_WIDTH-1]
                       && (cmd_diff > TIME_WIDTH'(cfg.command_timeout));

    vcsg_axis #(.VEL_WIDTH(VEL_WIDTH)) u_axis_x
    (
        .target_in (vx_in),
        .prev      (vx_reg),
        .limit     (cfg.speed_limit_x),
        .deadband  (cfg.deadband_pair[15:0]),
        .accel     (cfg.accel_limit_x),
        .dt        (dt_sat),
        .slewed    (vx_slew)
    );

    vcsg_axis #(.VEL_WIDTH(VEL_WIDTH)) u_axis_y
    (
        .target_in (vy_in),
        .prev      (vy_reg),
        .limit     (cfg.speed_limit_y),
        .deadband  ('0),
        .accel     (cfg.accel_limit_y),
        .dt        (dt_sat),
        .slewed    (vy_slew)
    );

    vcsg_axis #(.VEL_WIDTH(VEL_WIDTH)) u_axis_w
    (
        .target_in (wz_in),
        .prev      (wz_reg),
        .limit     (cfg.speed_limit_turn),
        .deadband  (cfg.deadband_pair[31:16]),
        .accel     (cfg.accel_limit_turn),
        .dt        (dt_sat),
        .slewed    (wz_slew)
    );

    always_comb
    begin
        mode_next      = mode_reg;
        step_time_next = step_time_reg;
        cmd_time_next  = cmd_time_reg;
        seen_next      = seen_reg;
        fault_next     = fault_reg;
        sent           = 1'b0;
        accepted       = 1'b1;
        zero_vel       = 1'b0;
        load_vel       = 1'b0;
        fault_req      = 1'b0;
        fault_val      = FAULT_NONE;

        case (opcode)
            OP_CONNECT:
            begin
                if (mode_reg == MODE_DISC)
                    mode_next = MODE_STANDBY;
            end
            OP_DISCONNECT:
            begin
                mode_next = MODE_DISC;
                zero_vel  = 1'b1;
                sent      = 1'b1;
            end
            OP_ENABLE:
            begin
                if (mode_reg != MODE_READY)
                    accepted = 1'b0;
                else
                begin
                    mode_next      = MODE_NAV;
                    seen_next      = 1'b0;
                    step_time_next = now;
                    zero_vel       = 1'b1;
                end
            end
            OP_DISABLE:
            begin
                if (mode_reg == MODE_NAV)
                begin
                    mode_next = MODE_READY;
                    zero_vel  = 1'b1;
                    sent      = 1'b1;
                end
            end
            OP_READY:
            begin
                if (mode_reg == MODE_STANDBY)
                    mode_next = MODE_READY;
            end
            OP_COMMAND:
            begin
                cmd_time_next = now;
                seen_next     = 1'b1;
                sent          = 1'b1;
                if (mode_reg != MODE_NAV)
                    zero_vel = 1'b1;
                else
                begin
                    step_time_next = now;
                    load_vel       = (step_dt != '0);
                end
            end
            OP_TICK:
            begin
                if (mode_reg == MODE_NAV && seen_reg && timed_out)
                begin
                    fault_req = 1'b1;
                    fault_val = FAULT_TIMEOUT;
                end
            end
            OP_ESTOP:
            begin
                mode_next = MODE_ESTOP;
                zero_vel  = 1'b1;
                sent      = 1'b1;
            end
            OP_CLEAR_ESTOP:
            begin
                if (mode_reg != MODE_ESTOP)
                    accepted = 1'b0;
                else
                begin
                    mode_next  = MODE_STANDBY;
                    fault_next = FAULT_NONE;
                end
            end
            OP_TF_STALE:
            begin
                fault_req = 1'b1;
                fault_val = FAULT_TF;
            end
            OP_SENSOR_STALE:
            begin
                fault_req = 1'b1;
                fault_val = FAULT_SENSOR;
            end
            OP_BRIDGE_ERROR:
            begin
                fault_req = 1'b1;
                fault_val = FAULT_BRIDGE;
            end
            OP_COLLISION:
            begin
                zero_vel = 1'b1;
                sent     = 1'b1;
            end
            OP_CLEAR_FAULT:
            begin
                if (mode_reg != MODE_FAULT)
                    accepted = 1'b0;
                else
                begin
                    mode_next  = MODE_STANDBY;
                    fault_next = FAULT_NONE;
                end
            end
            default:
            begin
                accepted = 1'b1;
            end
        endcase

        // e-stop blocks every fault
        if (fault_req && mode_reg != MODE_ESTOP)
        begin
            mode_next  = MODE_FAULT;
            fault_next = fault_val;
            zero_vel   = 1'b1;
            sent       = 1'b1;
        end
    end

    always_comb
    begin
        if (zero_vel)
        begin
            vx_next = '0;
            vy_next = '0;
            wz_next = '0;
        end
        else if (load_vel)
        begin
            vx_next = vx_slew;
            vy_next = vy_slew;
            wz_next = wz_slew;
        end
        else
        begin
            vx_next = vx_reg;
            vy_next = vy_reg;
            wz_next = wz_reg;
        end
    end

    assign status.sent       = sent;
    assign status.accepted   = accepted;
    assign status.mode       = mode_code(mode_next);
    assign status.fault_code = fault_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DISC;
            vx_reg        <= '0;
            vy_reg        <= '0;
            wz_reg        <= '0;
            step_time_reg <= '0;
            cmd_time_reg  <= '0;
            seen_reg      <= 1'b0;
            fault_reg     <= FAULT_NONE;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            wz_reg        <= wz_next;
            step_time_reg <= step_time_next;
            cmd_time_reg  <= cmd_time_next;
            seen_reg      <= seen_next;
            fault_reg     <= fault_next;
        end
    end

endmodule

FILE: rtl/velocity_command_safety_governor_unit.sv
// Safety governor for three-axis velocity commands. Each event item (opcode in
// s_tuser, timestamp and requested velocities in s_tdata) is captured in an
// input register and evaluated from it against the mode machine, watchdog,
// per-axis clamp and slew logic and the x and turn deadbands; exactly one
// result item leaves through the output register for every event. Throughput
// is one item per cycle while m_tready does not stall the output register, set
// by the state update of the mode and last-velocity registers. Configuration
// registers are to be written by the user through cfg_we/cfg_addr/cfg_wdata
// only while no item is in flight; the block itself does not enforce this;
// command_timeout resets to 500 ms, all other registers to zero, and the mode
// resets to disconnected.
module velocity_command_safety_governor_unit
#(
    parameter int VEL_WIDTH  = 16,
    parameter int TIME_WIDTH = 32,
    localparam int IN_BITS   = vcsg_pkg::TS_W + 3 * VEL_WIDTH,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 3 * VEL_WIDTH + 2 + 2 * vcsg_pkg::CODE_W,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // timestamp_ms, vx_in, vy_in, wz_in
    input  logic [IN_W-1:0]                    s_tdata,
    // opcode
    input  logic [vcsg_pkg::OPCODE_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // vx_out, vy_out, wz_out, sent, accepted, mode, fault_code
    output logic [OUT_W-1:0]                   m_tdata,
    input  logic                               cfg_we,
    input  logic [vcsg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [vcsg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import vcsg_pkg::*;

    cfg_t                        cfg;
    logic                        in_valid_reg;
    logic [OPCODE_W-1:0]         op_reg;
    logic [TS_W-1:0]             ts_reg;
    logic signed [VEL_WIDTH-1:0] vx_in_reg;
    logic signed [VEL_WIDTH-1:0] vy_in_reg;
    logic signed [VEL_WIDTH-1:0] wz_in_reg;

    logic                        out_valid_reg;
    logic signed [VEL_WIDTH-1:0] vx_out_reg;
    logic signed [VEL_WIDTH-1:0] vy_out_reg;
    logic signed [VEL_WIDTH-1:0] wz_out_reg;
    status_t                     status_reg;

    logic                        advance;
    logic                        fire;
    logic signed [VEL_WIDTH-1:0] vx_next;
    logic signed [VEL_WIDTH-1:0] vy_next;
    logic signed [VEL_WIDTH-1:0] wz_next;
    status_t                     status_next;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    vcsg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vcsg_core #(.VEL_WIDTH(VEL_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .opcode  (op_reg),
        .now     (TIME_WIDTH'(ts_reg)),
        .vx_in   (vx_in_reg),
        .vy_in   (vy_in_reg),
        .wz_in   (wz_in_reg),
        .cfg     (cfg),
        .vx_next (vx_next),
        .vy_next (vy_next),
        .wz_next (wz_next),
        .status  (status_next)
    );

    // input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser;
            ts_reg    <= s_tdata[TS_W-1:0];
            vx_in_reg <= s_tdata[TS_W +: VEL_WIDTH];
            vy_in_reg <= s_tdata[TS_W + VEL_WIDTH +: VEL_WIDTH];
            wz_in_reg <= s_tdata[TS_W + 2 * VEL_WIDTH +: VEL_WIDTH];
        end
    end

    // result item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            vx_out_reg <= vx_next;
            vy_out_reg <= vy_next;
            wz_out_reg <= wz_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({status_reg.fault_code, status_reg.mode,
                              status_reg.accepted, status_reg.sent,
                              wz_out_reg, vy_out_reg, vx_out_reg});

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import vcsg_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd14;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;
    localparam int RANDOM_PHASES = 7;
    localparam int EVENTS_PER_PHASE = 250;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [15:0]       vx;
        logic [15:0]       vy;
        logic [15:0]       wz;
        logic              sent;
        logic              accepted;
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] fault;
    } gov_result_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [31:0]         ts;
        logic [15:0]         vx;
        logic [15:0]         vy;
        logic [15:0]         wz;
        logic                known;
        gov_result_t         want;
    } gov_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // timestamp_ms, vx_in, vy_in, wz_in
    logic [79:0] s_tdata = '0;
    // opcode
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // vx_out, vy_out, wz_out, sent, accepted, mode, fault_code
    logic [55:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // governor state mirror
    logic [CODE_W-1:0] gov_mode;
    logic [CODE_W-1:0] gov_fault;
    logic [15:0]       last_vel [0:2];
    logic [31:0]       step_time;
    logic [31:0]       cmd_time;
    logic              cmd_seen;
    logic [14:0]       speed_lim [0:2];
    logic [31:0]       deadband;
    logic [15:0]       accel_lim [0:2];
    logic [15:0]       wdog_ms;

    gov_result_t pending_results[$];
    gov_event_t  directed_rows[$];

    int  error_count = 0;
    int  events_sent = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  input_stall_cycles = 0;
    bit  sender_idle = 1'b1;
    bit  sink_idle = 1'b1;
    bit  hold_request = 1'b0;

    velocity_command_safety_governor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clamp_axis(input logic [15:0] v, input logic [14:0] lim);
        longint s;
        longint l;
        s = longint'($signed(v));
        l = longint'(lim);
        if (s > l)
            return l;
        if (s < -l)
            return -l;
        return s;
    endfunction

    function automatic logic [15:0] slew_toward(input logic [15:0] prev, input longint target,
                                                input logic [15:0] accel, input logic [31:0] dt);
        longint p;
        longint max_step;
        longint delta;
        p = longint'($signed(prev));
        max_step = (longint'(accel) * longint'(dt)) >> 8;
        delta = target - p;
        if (delta > max_step)
            delta = max_step;
        if (delta < -max_step)
            delta = -max_step;
        return 16'(p + delta);
    endfunction

    function automatic gov_result_t govern_event(input gov_event_t ev);
        gov_result_t r;
        logic [31:0] dt;
        logic        zero_out;
        logic        fault_hit;
        logic [CODE_W-1:0] fcode;
        longint tx;
        longint ty;
        longint tw;
        r = '0;
        r.accepted = 1'b1;
        zero_out = 1'b0;
        fault_hit = 1'b0;
        fcode = FAULT_NONE;
        case (ev.op)
            OP_CONNECT:
                if (gov_mode == MODE_CODE_DISC)
                    gov_mode = MODE_CODE_STANDBY;
            OP_DISCONNECT:
            begin
                gov_mode = MODE_CODE_DISC;
                zero_out = 1'b1;
            end
            OP_ENABLE:
                if (gov_mode != MODE_CODE_READY)
                    r.accepted = 1'b0;
                else
                begin
                    gov_mode = MODE_CODE_NAV;
                    cmd_seen = 1'b0;
                    step_time = ev.ts;
                    for (int a = 0; a < 3; a++)
                        last_vel[a] = '0;
                end
            OP_DISABLE:
                if (gov_mode == MODE_CODE_NAV)
                begin
                    gov_mode = MODE_CODE_READY;
                    zero_out = 1'b1;
                end
            OP_READY:
                if (gov_mode == MODE_CODE_STANDBY)
                    gov_mode = MODE_CODE_READY;
            OP_COMMAND:
            begin
                cmd_time = ev.ts;
                cmd_seen = 1'b1;
                if (gov_mode != MODE_CODE_NAV)
                    zero_out = 1'b1;
                else
                begin
                    tx = clamp_axis(ev.vx, speed_lim[0]);
                    ty = clamp_axis(ev.vy, speed_lim[1]);
                    tw = clamp_axis(ev.wz, speed_lim[2]);
                    if ((tx < 0 ? -tx : tx) < longint'(deadband[15:0]))
                        tx = 0;
                    if ((tw < 0 ? -tw : tw) < longint'(deadband[31:16]))
                        tw = 0;
                    dt = ev.ts - step_time;
                    if (dt[31])
                        dt = '0;
                    if (dt != 0)
                    begin
                        last_vel[0] = slew_toward(last_vel[0], tx, accel_lim[0], dt);
                        last_vel[1] = slew_toward(last_vel[1], ty, accel_lim[1], dt);
                        last_vel[2] = slew_toward(last_vel[2], tw, accel_lim[2], dt);
                    end
                    step_time = ev.ts;
                    r.sent = 1'b1;
                end
            end
            OP_TICK:
            begin
                dt = ev.ts - cmd_time;
                if (gov_mode == MODE_CODE_NAV && cmd_seen && !dt[31] && dt > {16'd0, wdog_ms})
                begin
                    fault_hit = 1'b1;
                    fcode = FAULT_TIMEOUT;
                end
            end
            OP_ESTOP:
            begin
                gov_mode = MODE_CODE_ESTOP;
                zero_out = 1'b1;
            end
            OP_CLEAR_ESTOP:
                if (gov_mode != MODE_CODE_ESTOP)
                    r.accepted = 1'b0;
                else
                begin
                    gov_mode = MODE_CODE_STANDBY;
                    gov_fault = FAULT_NONE;
                end
            OP_TF_STALE:
            begin
                fault_hit = 1'b1;
                fcode = FAULT_TF;
            end
            OP_SENSOR_STALE:
            begin
                fault_hit = 1'b1;
                fcode = FAULT_SENSOR;
            end
            OP_BRIDGE_ERROR:
            begin
                fault_hit = 1'b1;
                fcode = FAULT_BRIDGE;
            end
            OP_COLLISION:
                zero_out = 1'b1;
            OP_CLEAR_FAULT:
                if (gov_mode != MODE_CODE_FAULT)
                    r.accepted = 1'b0;
                else
                begin
                    gov_mode = MODE_CODE_STANDBY;
                    gov_fault = FAULT_NONE;
                end
            default:
            begin
            end
        endcase
        // e-stop swallows every fault
        if (fault_hit && gov_mode != MODE_CODE_ESTOP)
        begin
            gov_mode = MODE_CODE_FAULT;
            gov_fault = fcode;
            zero_out = 1'b1;
        end
        if (zero_out)
        begin
            for (int a = 0; a < 3; a++)
                last_vel[a] = '0;
            r.sent = 1'b1;
        end
        r.vx = last_vel[0];
        r.vy = last_vel[1];
        r.wz = last_vel[2];
        r.mode = gov_mode;
        r.fault = gov_fault;
        return r;
    endfunction

    function automatic logic [3:0] next_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 4'($urandom_range(0, 15));
        case (gov_mode)
            MODE_CODE_DISC:
                return OP_CONNECT;
            MODE_CODE_STANDBY:
                return (r < 90) ? OP_READY : OP_CONNECT;
            MODE_CODE_READY:
                return (r < 88) ? OP_ENABLE : OP_DISABLE;
            MODE_CODE_NAV:
            begin
                if (r < 68)
                    return OP_COMMAND;
                if (r < 84)
                    return OP_TICK;
                if (r < 87)
                    return OP_DISABLE;
                if (r < 90)
                    return OP_COLLISION;
                if (r < 92)
                    return OP_ESTOP;
                if (r < 95)
                    return 4'($urandom_range(OP_TF_STALE, OP_BRIDGE_ERROR));
                return OP_COMMAND;
            end
            MODE_CODE_FAULT:
                return (r < 70) ? OP_CLEAR_FAULT : 4'($urandom_range(0, 15));
            default:
            begin
                if (r < 70)
                    return OP_CLEAR_ESTOP;
                if (r < 85)
                    return 4'($urandom_range(OP_TF_STALE, OP_BRIDGE_ERROR));
                return 4'($urandom_range(0, 15));
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_velocity(input logic [14:0] lim, input logic [15:0] db);
        int r;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: v = $urandom_range(0, 65535);
            4: v = $urandom_range(0, 1) ? 32'h7FFF : 32'hFFFF8000;
            5, 6: v = int'(lim) + $urandom_range(0, 4) - 2;
            7, 8: v = int'(db) + $urandom_range(0, 4) - 2;
            default: v = $urandom_range(0, 64) - 32;
        endcase
        if (r >= 5 && r <= 8 && $urandom_range(0, 1))
            v = -v;
        return v[15:0];
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SPEED_X:  speed_lim[0] = val[14:0];
            REG_SPEED_Y:  speed_lim[1] = val[14:0];
            REG_SPEED_W:  speed_lim[2] = val[14:0];
            REG_DEADBAND: deadband = val;
            REG_ACCEL_X:  accel_lim[0] = val[15:0];
            REG_ACCEL_Y:  accel_lim[1] = val[15:0];
            REG_ACCEL_W:  accel_lim[2] = val[15:0];
            default:      wdog_ms = val[15:0];
        endcase
        @(posedge clk);
    endtask

    task automatic program_settings(input logic [31:0] lx, input logic [31:0] ly,
                                    input logic [31:0] lw, input logic [31:0] db,
                                    input logic [31:0] ax, input logic [31:0] ay,
                                    input logic [31:0] aw, input logic [31:0] tmo,
                                    input bit keep_timeout);
        write_reg(REG_SPEED_X, lx);
        write_reg(REG_SPEED_Y, ly);
        write_reg(REG_SPEED_W, lw);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_ACCEL_X, ax);
        write_reg(REG_ACCEL_Y, ay);
        write_reg(REG_ACCEL_W, aw);
        if (!keep_timeout)
            write_reg(REG_TIMEOUT, tmo);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_event(input gov_event_t ev);
        int gap;
        gov_result_t predicted;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= ev.op;
        s_tdata <= {ev.wz, ev.vy, ev.vx, ev.ts};
        @(posedge clk);
        while (!s_tready)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        predicted = govern_event(ev);
        pending_results.push_back(ev.known ? ev.want : predicted);
        events_sent++;
    endtask

    task automatic add_row(input logic [3:0] op, input logic [31:0] ts, input logic [15:0] vx,
                           input logic [15:0] vy, input logic [15:0] wz, input logic known,
                           input logic sent, input logic acc, input logic [2:0] mode,
                           input logic [2:0] fault);
        gov_event_t row;
        row.op = op;
        row.ts = ts;
        row.vx = vx;
        row.vy = vy;
        row.wz = wz;
        row.known = known;
        // every typed row expects zero velocity
        row.want = '{vx: 16'd0, vy: 16'd0, wz: 16'd0, sent: sent, accepted: acc,
                     mode: mode, fault: fault};
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    initial
    begin : sink
        int w;
        gov_result_t want;
        @(posedge rst_n);
        forever
        begin
            w = sink_idle ? $urandom_range(0, 14) : 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                w = HOLD_OFF_CYCLES;
            end
            if (w > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result item with nothing expected, got %h", $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("vx_out", $signed(want.vx), $signed(m_tdata[15:0]));
                check_field("vy_out", $signed(want.vy), $signed(m_tdata[31:16]));
                check_field("wz_out", $signed(want.wz), $signed(m_tdata[47:32]));
                check_field("sent", want.sent, m_tdata[48]);
                check_field("accepted", want.accepted, m_tdata[49]);
                check_field("mode", want.mode, m_tdata[52:50]);
                check_field("fault_code", want.fault, m_tdata[55:53]);
                results_checked++;
            end
        end
    end

    initial
    begin : stimulus
        gov_event_t ev;
        logic [31:0] now_ms;
        logic [31:0] lim [0:2];
        logic [31:0] acc [0:2];
        logic [31:0] db;
        logic [31:0] tmo;
        int r;

        gov_mode = MODE_CODE_DISC;
        gov_fault = FAULT_NONE;
        step_time = '0;
        cmd_time = '0;
        cmd_seen = 1'b0;
        deadband = '0;
        wdog_ms = TIMEOUT_RESET;
        for (int a = 0; a < 3; a++)
        begin
            last_vel[a] = '0;
            speed_lim[a] = '0;
            accel_lim[a] = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // timeout stays at its reset value for the watchdog rows
        program_settings(32'd32767, 32'd20000, 32'd16384, 32'h00C8_0064,
                         32'd65535, 32'd256, 32'd1000, 32'd0, 1'b1);

        add_row(OP_TICK, 32'd0, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_DISC, FAULT_NONE);
        add_row(OP_ENABLE, 32'd0, 16'h0, 16'h0, 16'h0, 1, 0, 0, MODE_CODE_DISC, FAULT_NONE);
        add_row(OP_CLEAR_ESTOP, 32'd1, 16'h0, 16'h0, 16'h0, 1, 0, 0, MODE_CODE_DISC, FAULT_NONE);
        add_row(OP_CLEAR_FAULT, 32'd2, 16'h0, 16'h0, 16'h0, 1, 0, 0, MODE_CODE_DISC, FAULT_NONE);
        add_row(OP_SPARE_LO, 32'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 1, MODE_CODE_DISC,
                FAULT_NONE);
        add_row(OP_SPARE_HI, 32'd4, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_DISC, FAULT_NONE);
        add_row(OP_COMMAND, 32'd10, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 1, 1, MODE_CODE_DISC,
                FAULT_NONE);
        add_row(OP_CONNECT, 32'd20, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_STANDBY, FAULT_NONE);
        add_row(OP_READY, 32'd30, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_READY, FAULT_NONE);
        add_row(OP_ENABLE, 32'd1000, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_NAV, FAULT_NONE);
        // same timestamp as the enable: nothing may move
        add_row(OP_COMMAND, 32'd1000, 16'h7FFF, 16'h8000, 16'h8000, 1, 1, 1, MODE_CODE_NAV,
                FAULT_NONE);
        add_row(OP_COMMAND, 32'd1010, 16'd50, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0);
        add_row(OP_COMMAND, 32'd1020, 16'hFF6A, 16'd1234, 16'hFF39, 0, 0, 0, 0, 0);
        add_row(OP_COMMAND, 32'd1005, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0);
        add_row(OP_TICK, 32'd1505, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0, 0);
        add_row(OP_TICK, 32'd1506, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_FAULT, FAULT_TIMEOUT);
        add_row(OP_ESTOP, 32'd1510, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_ESTOP, FAULT_TIMEOUT);
        add_row(OP_TF_STALE, 32'd1511, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_ESTOP,
                FAULT_TIMEOUT);
        add_row(OP_CLEAR_ESTOP, 32'd1512, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_STANDBY,
                FAULT_NONE);
        add_row(OP_READY, 32'd1513, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_READY, FAULT_NONE);
        add_row(OP_ENABLE, 32'h0000_1000, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_NAV,
                FAULT_NONE);
        // largest forward time step
        add_row(OP_COMMAND, 32'h8000_0FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0);
        add_row(OP_DISABLE, 32'h8000_1000, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_READY,
                FAULT_NONE);
        add_row(OP_COLLISION, 32'h8000_1001, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_READY,
                FAULT_NONE);
        add_row(OP_SENSOR_STALE, 32'h8000_1002, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_FAULT,
                FAULT_SENSOR);
        add_row(OP_BRIDGE_ERROR, 32'h8000_1003, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_FAULT,
                FAULT_BRIDGE);
        add_row(OP_CLEAR_FAULT, 32'h8000_1004, 16'h0, 16'h0, 16'h0, 1, 0, 1, MODE_CODE_STANDBY,
                FAULT_NONE);
        add_row(OP_DISCONNECT, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 1, 1, 1, MODE_CODE_DISC,
                FAULT_NONE);

        foreach (directed_rows[i])
            send_event(directed_rows[i]);

        now_ms = 32'h0000_0100;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            if (phase == 0)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lim[a] = 32'h7FFF;
                    acc[a] = 32'hFFFF;
                end
                db = 32'hFFFF_FFFF;
                tmo = 32'hFFFF;
            end
            else if (phase == 1)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lim[a] = '0;
                    acc[a] = '0;
                end
                db = '0;
                tmo = '0;
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lim[a] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(500, 8000);
                    acc[a] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 3000);
                end
                db = ($urandom_range(0, 5) == 0) ? $urandom
                     : {16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500))};
                tmo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 250);
            end
            program_settings(lim[0], lim[1], lim[2], db, acc[0], acc[1], acc[2], tmo, 1'b0);

            sender_idle = (phase != 2 && phase != 3);
            sink_idle = (phase != 2);
            // back-pressure burst: sink stalls while the source floods
            if (phase == 3)
                hold_request = 1'b1;

            for (int k = 0; k < EVENTS_PER_PHASE; k++)
            begin
                ev = '0;
                ev.op = next_opcode();
                r = $urandom_range(0, 99);
                if (r < 8)
                    now_ms = now_ms;
                else if (r < 15)
                    now_ms = now_ms - $urandom_range(1, 60);
                else if (r < 18)
                    now_ms = $urandom;
                else if (r < 24)
                    now_ms = now_ms + {16'd0, wdog_ms} + $urandom_range(0, 2) - 1;
                else
                    now_ms = now_ms + $urandom_range(1, 40);
                if (ev.op == OP_TICK && $urandom_range(0, 2) == 0)
                    now_ms = cmd_time + {16'd0, wdog_ms} + $urandom_range(0, 2) - 1;
                ev.ts = now_ms;
                ev.vx = pick_velocity(speed_lim[0], deadband[15:0]);
                ev.vy = pick_velocity(speed_lim[1], 16'd0);
                ev.wz = pick_velocity(speed_lim[2], deadband[31:16]);
                send_event(ev);
            end
        end
        drain();

        $display("%0d events (%0d directed) checked as %0d results under %0d register settings",
                 events_sent, directed_rows.size(), results_checked, settings_used);
        $display("source held off %0d cycles by output back-pressure, %0d errors",
                 input_stall_cycles, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
